/* src/nmea_gga_sentence_parser_top_defines.svh */
// assertion macros for the gga sentence parser
`ifndef NMEA_GGA_SENTENCE_PARSER_TOP_DEFINES_SVH
`define NMEA_GGA_SENTENCE_PARSER_TOP_DEFINES_SVH

// plain property, sampled on clk_i, off while rst_ni is low
`define NGP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// implication, sampled on clk_i, off while rst_ni is low
`define NGP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/nmea_gga_pkg.sv */
// shared types, constants and helpers of the gga sentence parser
`default_nettype none

package nmea_gga_pkg;

  // character codes
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_A      = 8'h41;

  // header positions ('$' is position 0)
  localparam logic [2:0] HDR_START = 3'd1;
  localparam logic [2:0] HDR_TYPE0 = 3'd3;
  localparam logic [2:0] HDR_TYPE1 = 3'd4;
  localparam logic [2:0] HDR_TYPE2 = 3'd5;
  localparam logic [2:0] HDR_SKIP  = 3'd6;
  localparam logic [2:0] HDR_DONE  = 3'd7;

  // field numbers within the sentence body
  localparam logic [3:0] FLD_NONE     = 4'd0;
  localparam logic [3:0] FLD_TIME     = 4'd1;
  localparam logic [3:0] FLD_LAT      = 4'd2;
  localparam logic [3:0] FLD_LAT_HEMI = 4'd3;
  localparam logic [3:0] FLD_LON      = 4'd4;
  localparam logic [3:0] FLD_LON_HEMI = 4'd5;
  localparam logic [3:0] FLD_FIX      = 4'd6;
  localparam logic [3:0] FLD_SATS     = 4'd7;
  localparam logic [3:0] FLD_MAX      = 4'd15;
  localparam logic [3:0] POS_MAX      = 4'd15;

  // fraction of minutes to seconds: floor(frac * 60 / 10000) = floor(frac * 3 / 500),
  // done as floor(frac * SEC_RECIP / 2**SEC_SHIFT), exact for frac below 47662
  localparam int unsigned FRAC_W    = 14;
  localparam int unsigned RECIP_W   = 15;
  localparam int unsigned PROD_W    = FRAC_W + RECIP_W;
  localparam int unsigned SEC_SHIFT = 22;
  localparam logic [RECIP_W-1:0] SEC_RECIP = 15'd25166;

  // one result word
  typedef struct packed {
    logic [6:0]  utc_hour;
    logic [6:0]  utc_minute;
    logic [6:0]  utc_second;
    logic [6:0]  lat_degrees;
    logic [6:0]  lat_minutes;
    logic [5:0]  lat_seconds;
    logic [9:0]  lon_degrees;
    logic [6:0]  lon_minutes;
    logic [5:0]  lon_seconds;
    logic [15:0] hemisphere_chars;
    logic [3:0]  fix_quality;
    logic [6:0]  satellite_count;
  } res_t;

  // decimal digit value, non-digits count as zero
  function automatic logic [3:0] digit_of(input logic [7:0] b);
    logic [7:0] diff;
    diff = b - CH_ZERO;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      return diff[3:0];
    end
    return 4'd0;
  endfunction

  // whole seconds from a four-digit fraction of a minute
  function automatic logic [5:0] frac_to_sec(input logic [FRAC_W-1:0] frac);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(frac) * PROD_W'(SEC_RECIP);
    return prod[SEC_SHIFT +: 6];
  endfunction

endpackage

`default_nettype wire

/* src/nmea_gga_if.sv */
// handshake channels of the gga sentence parser: received bytes and decoded fixes
`default_nettype none

interface nmea_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nmea_res_if;
  logic        valid;
  logic        ready;
  logic [6:0]  utc_hour;
  logic [6:0]  utc_minute;
  logic [6:0]  utc_second;
  logic [6:0]  lat_degrees;
  logic [6:0]  lat_minutes;
  logic [5:0]  lat_seconds;
  logic [9:0]  lon_degrees;
  logic [6:0]  lon_minutes;
  logic [5:0]  lon_seconds;
  logic [15:0] hemisphere_chars;
  logic [3:0]  fix_quality;
  logic [6:0]  satellite_count;

  modport source (
    output valid, input ready,
    output utc_hour, output utc_minute, output utc_second,
    output lat_degrees, output lat_minutes, output lat_seconds,
    output lon_degrees, output lon_minutes, output lon_seconds,
    output hemisphere_chars, output fix_quality, output satellite_count
  );
  modport sink (
    input valid, output ready,
    input utc_hour, input utc_minute, input utc_second,
    input lat_degrees, input lat_minutes, input lat_seconds,
    input lon_degrees, input lon_minutes, input lon_seconds,
    input hemisphere_chars, input fix_quality, input satellite_count
  );
endinterface

`default_nettype wire

/* src/nmea_gga_sentence_parser_top.sv */
// gga sentence parser: byte-wise sentence decoder with a two-word result buffer
//
// Usage:
//   rx_i takes one received UART byte per word. A '$' opens a sentence and a
//   carriage return closes it; header characters 3 to 5 must read "GGA".
//   res_o gives one decoded fix (time, latitude, longitude, hemisphere
//   letters, fix quality, satellite count) for each closed GGA sentence;
//   other sentences and stray bytes give nothing.
//   Throughput: one byte per cycle unless both result words are full. Each
//   byte updates the parser state in the cycle it is taken; the fix of a
//   closing carriage return is in the output register the cycle after that
//   byte is taken, or in the skid word while the output register still waits.
//   The output side is an output register plus one skid word. Bytes keep
//   flowing while a fix waits to be taken; rx_i.ready drops only when both
//   words are full, and rises again the cycle after res_o.ready takes one.
//   Reset (rst_ni low, asynchronous) returns the parser to idle, waiting for
//   '$', and empties both result words.
//   Missing or non-digit characters at digit positions count as zero;
//   fractional minutes become whole seconds as frac * 60 / 10000, truncated.
`default_nettype none

`include "nmea_gga_sentence_parser_top_defines.svh"

module nmea_gga_sentence_parser_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  nmea_rx_if.sink    rx_i,
  nmea_res_if.source res_o
);
  import nmea_gga_pkg::*;

  // parser state
  logic        capturing_q, capturing_d;
  logic [2:0]  char_idx_q, char_idx_d;
  logic        type_ok_q, type_ok_d;
  logic [3:0]  field_num_q, field_num_d;
  logic [3:0]  field_pos_q, field_pos_d;
  logic [6:0]  hour_acc_q, hour_acc_d;
  logic [6:0]  minute_acc_q, minute_acc_d;
  logic [6:0]  second_acc_q, second_acc_d;
  logic [6:0]  lat_deg_acc_q, lat_deg_acc_d;
  logic [6:0]  lat_min_acc_q, lat_min_acc_d;
  logic [FRAC_W-1:0] lat_frac_acc_q, lat_frac_acc_d;
  logic [9:0]  lon_deg_acc_q, lon_deg_acc_d;
  logic [6:0]  lon_min_acc_q, lon_min_acc_d;
  logic [FRAC_W-1:0] lon_frac_acc_q, lon_frac_acc_d;
  logic [15:0] hemi_acc_q, hemi_acc_d;
  logic [3:0]  fix_acc_q, fix_acc_d;
  logic [6:0]  sats_acc_q, sats_acc_d;

  // result buffer
  logic res_valid_q, res_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t res_q, res_d;
  res_t skid_q, skid_d;
  res_t new_res;

  logic       rx_fire;
  logic       res_fire;
  logic       produce;
  logic [7:0] b;
  logic [3:0] d;

  assign rx_i.ready = ~skid_valid_q;
  assign rx_fire    = rx_i.valid & rx_i.ready;
  assign res_fire   = res_valid_q & res_o.ready;
  assign b          = rx_i.rx_byte;
  assign d          = digit_of(b);

  // per-byte parser update
  always_comb begin
    capturing_d    = capturing_q;
    char_idx_d     = char_idx_q;
    type_ok_d      = type_ok_q;
    field_num_d    = field_num_q;
    field_pos_d    = field_pos_q;
    hour_acc_d     = hour_acc_q;
    minute_acc_d   = minute_acc_q;
    second_acc_d   = second_acc_q;
    lat_deg_acc_d  = lat_deg_acc_q;
    lat_min_acc_d  = lat_min_acc_q;
    lat_frac_acc_d = lat_frac_acc_q;
    lon_deg_acc_d  = lon_deg_acc_q;
    lon_min_acc_d  = lon_min_acc_q;
    lon_frac_acc_d = lon_frac_acc_q;
    hemi_acc_d     = hemi_acc_q;
    fix_acc_d      = fix_acc_q;
    sats_acc_d     = sats_acc_q;
    produce        = 1'b0;

    if (rx_fire) begin
      if (!capturing_q) begin
        if (b == CH_DOLLAR) begin
          capturing_d    = 1'b1;
          char_idx_d     = HDR_START;
          type_ok_d      = 1'b1;
          field_num_d    = FLD_NONE;
          field_pos_d    = '0;
          hour_acc_d     = '0;
          minute_acc_d   = '0;
          second_acc_d   = '0;
          lat_deg_acc_d  = '0;
          lat_min_acc_d  = '0;
          lat_frac_acc_d = '0;
          lon_deg_acc_d  = '0;
          lon_min_acc_d  = '0;
          lon_frac_acc_d = '0;
          hemi_acc_d     = '0;
          fix_acc_d      = '0;
          sats_acc_d     = '0;
        end
      end else if (b == CH_CR) begin
        capturing_d = 1'b0;
        produce     = type_ok_q && (char_idx_q >= HDR_SKIP);
      end else if (char_idx_q < HDR_SKIP) begin
        // header: check the sentence type letters
        if ((char_idx_q == HDR_TYPE0 || char_idx_q == HDR_TYPE1) && b != CH_G) begin
          type_ok_d = 1'b0;
        end
        if (char_idx_q == HDR_TYPE2 && b != CH_A) begin
          type_ok_d = 1'b0;
        end
        char_idx_d = char_idx_q + 3'd1;
      end else if (char_idx_q == HDR_SKIP) begin
        char_idx_d  = HDR_DONE;
        field_num_d = FLD_TIME;
        field_pos_d = '0;
      end else if (b == CH_COMMA) begin
        if (field_num_q != FLD_MAX) begin
          field_num_d = field_num_q + 4'd1;
        end
        field_pos_d = '0;
      end else begin
        // field body: digit at a fixed position
        case (field_num_q)
          FLD_TIME: begin
            case (field_pos_q)
              4'd0: hour_acc_d   = hour_acc_q + 7'(d) * 7'd10;
              4'd1: hour_acc_d   = hour_acc_q + 7'(d);
              4'd2: minute_acc_d = minute_acc_q + 7'(d) * 7'd10;
              4'd3: minute_acc_d = minute_acc_q + 7'(d);
              4'd4: second_acc_d = second_acc_q + 7'(d) * 7'd10;
              4'd5: second_acc_d = second_acc_q + 7'(d);
              default: ;
            endcase
          end
          FLD_LAT: begin
            case (field_pos_q)
              4'd0: lat_deg_acc_d  = lat_deg_acc_q + 7'(d) * 7'd10;
              4'd1: lat_deg_acc_d  = lat_deg_acc_q + 7'(d);
              4'd2: lat_min_acc_d  = lat_min_acc_q + 7'(d) * 7'd10;
              4'd3: lat_min_acc_d  = lat_min_acc_q + 7'(d);
              4'd5: lat_frac_acc_d = lat_frac_acc_q + FRAC_W'(d) * FRAC_W'(1000);
              4'd6: lat_frac_acc_d = lat_frac_acc_q + FRAC_W'(d) * FRAC_W'(100);
              4'd7: lat_frac_acc_d = lat_frac_acc_q + FRAC_W'(d) * FRAC_W'(10);
              4'd8: lat_frac_acc_d = lat_frac_acc_q + FRAC_W'(d);
              default: ;
            endcase
          end
          FLD_LAT_HEMI: begin
            if (field_pos_q == 4'd0) begin
              hemi_acc_d[15:8] = b;
            end
          end
          FLD_LON: begin
            case (field_pos_q)
              4'd0: lon_deg_acc_d  = lon_deg_acc_q + 10'(d) * 10'd100;
              4'd1: lon_deg_acc_d  = lon_deg_acc_q + 10'(d) * 10'd10;
              4'd2: lon_deg_acc_d  = lon_deg_acc_q + 10'(d);
              4'd3: lon_min_acc_d  = lon_min_acc_q + 7'(d) * 7'd10;
              4'd4: lon_min_acc_d  = lon_min_acc_q + 7'(d);
              4'd6: lon_frac_acc_d = lon_frac_acc_q + FRAC_W'(d) * FRAC_W'(1000);
              4'd7: lon_frac_acc_d = lon_frac_acc_q + FRAC_W'(d) * FRAC_W'(100);
              4'd8: lon_frac_acc_d = lon_frac_acc_q + FRAC_W'(d) * FRAC_W'(10);
              4'd9: lon_frac_acc_d = lon_frac_acc_q + FRAC_W'(d);
              default: ;
            endcase
          end
          FLD_LON_HEMI: begin
            if (field_pos_q == 4'd0) begin
              hemi_acc_d[7:0] = b;
            end
          end
          FLD_FIX: begin
            if (field_pos_q == 4'd0) begin
              fix_acc_d = d;
            end
          end
          FLD_SATS: begin
            case (field_pos_q)
              4'd0: sats_acc_d = sats_acc_q + 7'(d) * 7'd10;
              4'd1: sats_acc_d = sats_acc_q + 7'(d);
              default: ;
            endcase
          end
          default: ;
        endcase
        if (field_pos_q != POS_MAX) begin
          field_pos_d = field_pos_q + 4'd1;
        end
      end
    end
  end

  // result word from the accumulators
  always_comb begin
    new_res.utc_hour         = hour_acc_q;
    new_res.utc_minute       = minute_acc_q;
    new_res.utc_second       = second_acc_q;
    new_res.lat_degrees      = lat_deg_acc_q;
    new_res.lat_minutes      = lat_min_acc_q;
    new_res.lat_seconds      = frac_to_sec(lat_frac_acc_q);
    new_res.lon_degrees      = lon_deg_acc_q;
    new_res.lon_minutes      = lon_min_acc_q;
    new_res.lon_seconds      = frac_to_sec(lon_frac_acc_q);
    new_res.hemisphere_chars = hemi_acc_q;
    new_res.fix_quality      = fix_acc_q;
    new_res.satellite_count  = sats_acc_q;
  end

  // output register plus skid word
  always_comb begin
    res_valid_d  = res_valid_q;
    skid_valid_d = skid_valid_q;
    res_d        = res_q;
    skid_d       = skid_q;
    if (res_fire || !res_valid_q) begin
      if (skid_valid_q) begin
        res_valid_d  = 1'b1;
        res_d        = skid_q;
        skid_valid_d = produce;
        skid_d       = new_res;
      end else begin
        res_valid_d = produce;
        res_d       = new_res;
      end
    end else if (produce) begin
      skid_valid_d = 1'b1;
      skid_d       = new_res;
    end
  end

  // control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q    <= 1'b0;
      char_idx_q     <= '0;
      type_ok_q      <= 1'b0;
      field_num_q    <= FLD_NONE;
      field_pos_q    <= '0;
      hour_acc_q     <= '0;
      minute_acc_q   <= '0;
      second_acc_q   <= '0;
      lat_deg_acc_q  <= '0;
      lat_min_acc_q  <= '0;
      lat_frac_acc_q <= '0;
      lon_deg_acc_q  <= '0;
      lon_min_acc_q  <= '0;
      lon_frac_acc_q <= '0;
      hemi_acc_q     <= '0;
      fix_acc_q      <= '0;
      sats_acc_q     <= '0;
      res_valid_q    <= 1'b0;
      skid_valid_q   <= 1'b0;
    end else begin
      capturing_q    <= capturing_d;
      char_idx_q     <= char_idx_d;
      type_ok_q      <= type_ok_d;
      field_num_q    <= field_num_d;
      field_pos_q    <= field_pos_d;
      hour_acc_q     <= hour_acc_d;
      minute_acc_q   <= minute_acc_d;
      second_acc_q   <= second_acc_d;
      lat_deg_acc_q  <= lat_deg_acc_d;
      lat_min_acc_q  <= lat_min_acc_d;
      lat_frac_acc_q <= lat_frac_acc_d;
      lon_deg_acc_q  <= lon_deg_acc_d;
      lon_min_acc_q  <= lon_min_acc_d;
      lon_frac_acc_q <= lon_frac_acc_d;
      hemi_acc_q     <= hemi_acc_d;
      fix_acc_q      <= fix_acc_d;
      sats_acc_q     <= sats_acc_d;
      res_valid_q    <= res_valid_d;
      skid_valid_q   <= skid_valid_d;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    skid_q <= skid_d;
  end

  // output drive
  assign res_o.valid            = res_valid_q;
  assign res_o.utc_hour         = res_q.utc_hour;
  assign res_o.utc_minute       = res_q.utc_minute;
  assign res_o.utc_second       = res_q.utc_second;
  assign res_o.lat_degrees      = res_q.lat_degrees;
  assign res_o.lat_minutes      = res_q.lat_minutes;
  assign res_o.lat_seconds      = res_q.lat_seconds;
  assign res_o.lon_degrees      = res_q.lon_degrees;
  assign res_o.lon_minutes      = res_q.lon_minutes;
  assign res_o.lon_seconds      = res_q.lon_seconds;
  assign res_o.hemisphere_chars = res_q.hemisphere_chars;
  assign res_o.fix_quality      = res_q.fix_quality;
  assign res_o.satellite_count  = res_q.satellite_count;

  // checks on the parser and the result buffer
  `NGP_ASSERT(a_skid_behind_out, !skid_valid_q || res_valid_q, "skid word without output word")
  `NGP_ASSERT_IMP(a_skid_fill_stalled, $rose(skid_valid_q), $past(res_valid_q && !res_o.ready), "skid filled while output free")
  `NGP_ASSERT_IMP(a_res_from_cr, $rose(res_valid_q), $past(rx_fire && b == CH_CR), "result not caused by a carriage return")
  `NGP_ASSERT_IMP(a_field_after_hdr, field_num_q != FLD_NONE, char_idx_q == HDR_DONE, "field counted inside the header")

endmodule

`default_nettype wire

/* verif/tb.sv */
// testbench for the gga sentence parser: byte stimulus, fix prediction and scoreboard
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nmea_gga_pkg::*;

  localparam int ITEM_TARGET     = 1450; // bytes taken before the random sentences stop
  localparam int HOLD_CYCLES     = 400;  // long receiver hold-off
  localparam int WATCHDOG_CYCLES = 5000; // long hold plus the longest sender gap, several times over
  localparam int DRAIN_CYCLES    = 20;

  typedef struct {
    string text;
    bit    close;
    bit    typed;
    res_t  want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  nmea_rx_if  rx_bus ();
  nmea_res_if res_bus ();

  nmea_gga_sentence_parser_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_bus),
    .res_o  (res_bus)
  );

  // predictor state
  bit         in_sentence;
  logic [2:0] hdr_pos;
  bit         is_gga;
  logic [3:0] fld;
  logic [3:0] fpos;
  logic [6:0] hh, mm, ss;
  logic [6:0] lat_dd, lat_mm;
  logic [13:0] lat_frac;
  logic [9:0] lon_ddd;
  logic [6:0] lon_mm;
  logic [13:0] lon_frac;
  logic [15:0] hemi;
  logic [3:0] fixq;
  logic [6:0] sats;

  // scoreboard and run bookkeeping
  res_t        pending_fixes[$];
  logic [7:0]  line[$];
  row_t        script[$];
  bit          use_typed;
  res_t        typed_fix;
  bit          hold_req;
  int          errors;
  int          sent_bytes;
  int          fix_no;
  int          quiet_cycles;
  res_t        got_fix;
  res_t        want_fix;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one mismatch line, counted
  task automatic flag_error(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      flag_error($sformatf("fix %0d %s: got %0d, want %0d", fix_no, name, got, want));
    end
  endtask

  // gap length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sentence decoder, one byte at a time
  task automatic parse_byte(input logic [7:0] b, output bit done, output res_t fix);
    int dv;
    int p;
    done = 1'b0;
    fix  = '0;
    dv   = (b >= CH_ZERO && b <= CH_NINE) ? int'(b - CH_ZERO) : 0;
    p    = int'(fpos);
    if (!in_sentence) begin
      // idle: only a dollar opens a sentence
      if (b == CH_DOLLAR) begin
        in_sentence = 1'b1;
        hdr_pos  = HDR_START;
        is_gga   = 1'b1;
        fld      = FLD_NONE;
        fpos     = '0;
        hh = '0; mm = '0; ss = '0;
        lat_dd = '0; lat_mm = '0; lat_frac = '0;
        lon_ddd = '0; lon_mm = '0; lon_frac = '0;
        hemi = '0; fixq = '0; sats = '0;
      end
    end else if (b == CH_CR) begin
      // end of sentence: a fix only for a complete gga header
      in_sentence = 1'b0;
      if (is_gga && hdr_pos >= HDR_SKIP) begin
        done = 1'b1;
        fix.utc_hour         = hh;
        fix.utc_minute       = mm;
        fix.utc_second       = ss;
        fix.lat_degrees      = lat_dd;
        fix.lat_minutes      = lat_mm;
        fix.lat_seconds      = 6'((int'(lat_frac) * 60) / 10000);
        fix.lon_degrees      = lon_ddd;
        fix.lon_minutes      = lon_mm;
        fix.lon_seconds      = 6'((int'(lon_frac) * 60) / 10000);
        fix.hemisphere_chars = hemi;
        fix.fix_quality      = fixq;
        fix.satellite_count  = sats;
      end
    end else if (hdr_pos < HDR_SKIP) begin
      // header: type letters must read GGA
      if ((hdr_pos == HDR_TYPE0 || hdr_pos == HDR_TYPE1) && b != CH_G) is_gga = 1'b0;
      if (hdr_pos == HDR_TYPE2 && b != CH_A) is_gga = 1'b0;
      hdr_pos = hdr_pos + 3'd1;
    end else if (hdr_pos == HDR_SKIP) begin
      // last header byte is dropped whatever it is
      hdr_pos = HDR_DONE;
      fld     = FLD_TIME;
      fpos    = '0;
    end else if (b == CH_COMMA) begin
      if (fld != FLD_MAX) fld = fld + 4'd1;
      fpos = '0;
    end else begin
      // body byte at a fixed position of its field
      case (fld)
        FLD_TIME: begin
          case (p)
            0: hh = hh + 7'(dv * 10);
            1: hh = hh + 7'(dv);
            2: mm = mm + 7'(dv * 10);
            3: mm = mm + 7'(dv);
            4: ss = ss + 7'(dv * 10);
            5: ss = ss + 7'(dv);
            default: ;
          endcase
        end
        FLD_LAT: begin
          case (p)
            0: lat_dd   = lat_dd + 7'(dv * 10);
            1: lat_dd   = lat_dd + 7'(dv);
            2: lat_mm   = lat_mm + 7'(dv * 10);
            3: lat_mm   = lat_mm + 7'(dv);
            5: lat_frac = lat_frac + 14'(dv * 1000);
            6: lat_frac = lat_frac + 14'(dv * 100);
            7: lat_frac = lat_frac + 14'(dv * 10);
            8: lat_frac = lat_frac + 14'(dv);
            default: ;
          endcase
        end
        FLD_LAT_HEMI: begin
          if (p == 0) hemi[15:8] = b;
        end
        FLD_LON: begin
          case (p)
            0: lon_ddd  = lon_ddd + 10'(dv * 100);
            1: lon_ddd  = lon_ddd + 10'(dv * 10);
            2: lon_ddd  = lon_ddd + 10'(dv);
            3: lon_mm   = lon_mm + 7'(dv * 10);
            4: lon_mm   = lon_mm + 7'(dv);
            6: lon_frac = lon_frac + 14'(dv * 1000);
            7: lon_frac = lon_frac + 14'(dv * 100);
            8: lon_frac = lon_frac + 14'(dv * 10);
            9: lon_frac = lon_frac + 14'(dv);
            default: ;
          endcase
        end
        FLD_LON_HEMI: begin
          if (p == 0) hemi[7:0] = b;
        end
        FLD_FIX: begin
          if (p == 0) fixq = 4'(dv);
        end
        FLD_SATS: begin
          if (p == 0) sats = sats + 7'(dv * 10);
          else if (p == 1) sats = sats + 7'(dv);
        end
        default: ;
      endcase
      if (fpos != POS_MAX) fpos = fpos + 4'd1;
    end
  endtask

  // offer one byte until taken, then predict
  task automatic send_byte(input logic [7:0] b, input bit quiet);
    int   gap;
    bit   done;
    res_t fix;
    gap = quiet ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      rx_bus.valid = 1'b0;
    end
    @(negedge clk_i);
    rx_bus.valid   = 1'b1;
    rx_bus.rx_byte = b;
    @(posedge clk_i);
    while (!rx_bus.ready) @(posedge clk_i);
    sent_bytes++;
    parse_byte(b, done, fix);
    if (done) begin
      pending_fixes.push_back(use_typed ? typed_fix : fix);
    end
  endtask

  task automatic send_line(input bit quiet);
    logic [7:0] snap[$];
    snap = line;
    foreach (snap[i]) send_byte(snap[i], quiet);
  endtask

  task automatic add_row(input string text, input bit close, input bit typed, input res_t want);
    row_t r;
    r.text  = text;
    r.close = close;
    r.typed = typed;
    r.want  = want;
    script.push_back(r);
  endtask

  // any byte that neither ends the sentence nor splits a field
  function automatic logic [7:0] body_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_COMMA);
    return b;
  endfunction

  // mostly a decimal digit, now and then a stray byte
  function automatic logic [7:0] digit_char();
    if ($urandom_range(0, 9) == 0) return body_char();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line.push_back(s[i]);
  endtask

  task automatic put_digits(input int n);
    repeat (n) line.push_back(digit_char());
  endtask

  // ddmm.ffff or dddmm.ffff, sometimes mangled
  task automatic put_coord(input int whole);
    if ($urandom_range(0, 6) != 0) begin
      put_digits(whole);
      line.push_back(".");
      put_digits(($urandom_range(0, 9) < 7) ? 4 : $urandom_range(1, 6));
    end else begin
      put_digits($urandom_range(0, 14));
    end
  endtask

  task automatic put_letter(input string pair);
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) line.push_back(pair[$urandom_range(0, 1)]);
    else if (r == 8) line.push_back(body_char());
  endtask

  // gga sentence with random content, now and then mangled
  task automatic build_gga();
    line.delete();
    line.push_back(CH_DOLLAR);
    if ($urandom_range(0, 9) != 0) put_text("GP");
    else begin
      line.push_back(body_char());
      line.push_back(body_char());
    end
    put_text("GGA");
    line.push_back(($urandom_range(0, 9) == 0) ? body_char() : CH_COMMA);
    if ($urandom_range(0, 6) != 0) begin
      put_digits(6);
      if ($urandom_range(0, 1) == 1) put_text(".00");
    end else begin
      put_digits($urandom_range(0, 9));
    end
    line.push_back(CH_COMMA);
    put_coord(4);
    line.push_back(CH_COMMA);
    put_letter("NS");
    line.push_back(CH_COMMA);
    put_coord(5);
    line.push_back(CH_COMMA);
    put_letter("EW");
    line.push_back(CH_COMMA);
    put_digits(($urandom_range(0, 6) != 0) ? 1 : $urandom_range(0, 3));
    line.push_back(CH_COMMA);
    put_digits(($urandom_range(0, 6) != 0) ? 2 : $urandom_range(0, 4));
    repeat ($urandom_range(0, 8)) begin
      line.push_back(CH_COMMA);
      put_digits($urandom_range(0, 5));
    end
    line.push_back(CH_CR);
  endtask

  // idle noise, bad type, cut short, or missing end
  task automatic build_broken();
    int         k;
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: begin
        line.delete();
        repeat ($urandom_range(1, 10)) line.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        build_gga();
        k = $urandom_range(3, 5);
        do b = 8'($urandom_range(0, 255)); while (b == line[k] || b == CH_CR);
        line[k] = b;
      end
      2: begin
        build_gga();
        k = $urandom_range(1, line.size() - 1);
        line = line[0:k-1];
        line.push_back(CH_CR);
      end
      default: begin
        build_gga();
        void'(line.pop_back());
      end
    endcase
  endtask

  // stimulus
  initial begin
    bit pressed;
    rst_ni         = 1'b0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    res_bus.ready  = 1'b0;
    hold_req       = 1'b0;
    use_typed      = 1'b0;
    errors         = 0;
    sent_bytes     = 0;
    in_sentence    = 1'b0;
    hdr_pos        = '0;
    is_gga         = 1'b0;
    fld            = FLD_NONE;
    fpos           = '0;
    hh = '0; mm = '0; ss = '0;
    lat_dd = '0; lat_mm = '0; lat_frac = '0;
    lon_ddd = '0; lon_mm = '0; lon_frac = '0;
    hemi = '0; fixq = '0; sats = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed sentences
    add_row("$GPGGA", 1, 1, '0);
    add_row("$GPGGA,000000,0000.0000,S,00000.0000,W,0,00", 1, 1,
            res_t'{hemisphere_chars: 16'h5357, default: '0});
    add_row("$GPGGA,999999,9999.9999,N,99999.9999,E,9,99", 1, 1,
            res_t'{utc_hour: 7'd99, utc_minute: 7'd99, utc_second: 7'd99,
                   lat_degrees: 7'd99, lat_minutes: 7'd99, lat_seconds: 6'd59,
                   lon_degrees: 10'd999, lon_minutes: 7'd99, lon_seconds: 6'd59,
                   hemisphere_chars: 16'h4e45, fix_quality: 4'd9,
                   satellite_count: 7'd99});
    add_row("$GPGGA,,,,,,,", 1, 1, '0);
    add_row("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47", 1, 0, '0);
    add_row("$GPGG", 1, 0, '0);
    add_row("$", 1, 0, '0);
    add_row("", 1, 0, '0);
    add_row("junk,GGA\377", 0, 0, '0);
    add_row("$GPRMC,123519,A,4807.038,N,01131.000,E", 1, 0, '0);
    add_row("$GPAGA,123519,4807.0380,N,01131.0000,E,1,08", 1, 0, '0);
    add_row("$GPGAA,123519,4807.0380,N,01131.0000,E,1,08", 1, 0, '0);
    add_row("$GPGGB,123519,4807.0380,N,01131.0000,E,1,08", 1, 0, '0);
    add_row("$GPGGA#235959,5133.1234,N,00007.5678,W,2,12", 1, 0, '0);
    add_row("$GPGGA,1a:3b5c,4x07.03z0,\377,0 131.0$00,e,Q,?8", 1, 0, '0);
    add_row("$GPGGA,12$519,48$7.0380,N,01131.0000,E,1,08", 1, 0, '0);
    add_row("$$GPGGA,010203,1111.1111,N", 1, 0, '0);
    add_row("$GPGGA,01,02,,0,,3,4567,89,1,2,3,4,5,6,7,8,9,10,11,12,13,14", 1, 0, '0);
    add_row("$GPGGA,12345678901234567890,1234.56789012345678,SS,", 1, 0, '0);

    // extreme byte values while idle
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    foreach (script[i]) begin
      line.delete();
      put_text(script[i].text);
      if (script[i].close) line.push_back(CH_CR);
      use_typed = script[i].typed;
      typed_fix = script[i].want;
      send_line($urandom_range(0, 3) == 0);
      use_typed = 1'b0;
    end

    // random sentences, one burst against a stalled receiver
    pressed = 1'b0;
    while (sent_bytes < ITEM_TARGET) begin
      if (!pressed && sent_bytes > ITEM_TARGET / 2) begin
        pressed  = 1'b1;
        hold_req = 1'b1;
        repeat (8) begin
          build_gga();
          send_line(1'b1);
        end
      end else begin
        if ($urandom_range(0, 4) != 0) build_gga();
        else build_broken();
        send_line($urandom_range(0, 3) == 0);
      end
    end
    @(negedge clk_i);
    rx_bus.valid = 1'b0;

    // drain
    while (pending_fixes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver: random stalls, calm stretches, one long hold-off
  initial begin
    int stall;
    int calm;
    stall = 0;
    calm  = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        res_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (calm > 0) calm--;
      else if ($urandom_range(0, 99) == 0) calm = $urandom_range(50, 200);
      if (stall > 0) begin
        res_bus.ready = 1'b0;
        stall--;
      end else begin
        res_bus.ready = 1'b1;
        stall = (calm > 0) ? 0 : idle_len();
      end
    end
  end

  // compare each taken fix with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      got_fix = '{res_bus.utc_hour, res_bus.utc_minute, res_bus.utc_second,
                  res_bus.lat_degrees, res_bus.lat_minutes, res_bus.lat_seconds,
                  res_bus.lon_degrees, res_bus.lon_minutes, res_bus.lon_seconds,
                  res_bus.hemisphere_chars, res_bus.fix_quality,
                  res_bus.satellite_count};
      if (pending_fixes.size() == 0) begin
        flag_error($sformatf("fix %0d arrived with none pending", fix_no));
      end else begin
        want_fix = pending_fixes.pop_front();
        check_field("utc_hour", got_fix.utc_hour, want_fix.utc_hour);
        check_field("utc_minute", got_fix.utc_minute, want_fix.utc_minute);
        check_field("utc_second", got_fix.utc_second, want_fix.utc_second);
        check_field("lat_degrees", got_fix.lat_degrees, want_fix.lat_degrees);
        check_field("lat_minutes", got_fix.lat_minutes, want_fix.lat_minutes);
        check_field("lat_seconds", got_fix.lat_seconds, want_fix.lat_seconds);
        check_field("lon_degrees", got_fix.lon_degrees, want_fix.lon_degrees);
        check_field("lon_minutes", got_fix.lon_minutes, want_fix.lon_minutes);
        check_field("lon_seconds", got_fix.lon_seconds, want_fix.lon_seconds);
        check_field("hemisphere_chars", got_fix.hemisphere_chars,
                    want_fix.hemisphere_chars);
        check_field("fix_quality", got_fix.fix_quality, want_fix.fix_quality);
        check_field("satellite_count", got_fix.satellite_count,
                    want_fix.satellite_count);
      end
      fix_no++;
    end
  end

  // watchdog on cycles with no word taken on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_bus.valid && rx_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("timeout: %0d fixes still pending", pending_fixes.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
